[sv/pfsf_pkg.sv]
`timescale 1ns / 1ps

package pfsf_pkg;

   localparam int unsigned DATA_W   = 32;
   localparam int unsigned SYM_W    = 8;
   localparam int unsigned OP_W     = 2;
   localparam int unsigned TONE_W   = 39;
   localparam int unsigned PEND_W   = 8;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
   localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_DIAL   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD = 1'b1;

   localparam logic [DATA_W-1:0] DIAL_RESET   = 32'd14095600;
   localparam logic [DATA_W-1:0] PERIOD_RESET = 32'd682667;
   localparam logic [DATA_W-1:0] FIRST_DELAY  = 32'd20000;

   localparam logic [6:0]  CENTI_MUL  = 7'd100;
   localparam logic [20:0] OFFS_MUL   = 21'd1200000;
   localparam int unsigned OFFS_SHIFT = 13;
   localparam int unsigned OFFS_PROD_W = SYM_W + 21;
   localparam int unsigned OFFS_W      = OFFS_PROD_W - OFFS_SHIFT;

   typedef enum logic [1:0] {
      CMD_NOP,
      CMD_PUSH,
      CMD_TICK,
      CMD_CLEAR
   } cmd_type;

   typedef struct packed {
      cmd_type          cmd;
      logic [SYM_W-1:0] symbol;
   } cmd_item_type;

   typedef struct packed {
      logic         valid;
      cmd_item_type item;
   } queue_head_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_MUL,
      B_SUM
   } back_state_type;

   typedef struct packed {
      logic exec;
      logic do_mul;
      logic do_sum;
      logic q_pop;
   } back_ctrl_type;

endpackage

[sv/pfsf_front.sv]
`timescale 1ns / 1ps

module pfsf_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [pfsf_pkg::OP_W-1:0]   req_opcode,
   input  logic [pfsf_pkg::SYM_W-1:0]  req_symbol,
   output pfsf_pkg::queue_head_type    q_head,
   input  logic                        q_pop
);
   import pfsf_pkg::*;

   cmd_item_type entry_ff [2];
   cmd_item_type entry_in;
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   fill_ff, fill_in;
   logic         push;
   logic         pop;

   assign busy = (fill_ff == 2'd2);
   assign push = start && !busy;
   assign pop  = q_pop && (fill_ff != 2'd0);

   always_comb begin
      entry_in.symbol = req_symbol;
      case (req_opcode)
         OP_PUSH:  entry_in.cmd = CMD_PUSH;
         OP_TICK:  entry_in.cmd = CMD_TICK;
         OP_CLEAR: entry_in.cmd = CMD_CLEAR;
         default:  entry_in.cmd = CMD_NOP;
      endcase
   end

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   assign q_head.valid = (fill_ff != 2'd0);
   assign q_head.item  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

[sv/pfsf_back.sv]
`timescale 1ns / 1ps

module pfsf_back #(
   parameter int unsigned FIFO_DEPTH = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  pfsf_pkg::queue_head_type       q_head,
   output logic                           q_pop,
   input  logic [pfsf_pkg::DATA_W-1:0]    dial_freq_hz,
   input  logic [pfsf_pkg::DATA_W-1:0]    sym_period,
   output logic                           rsp_valid,
   output logic                           rsp_push_accepted,
   output logic                           rsp_tone_valid,
   output logic [pfsf_pkg::TONE_W-1:0]    rsp_tone_centihz,
   output logic [pfsf_pkg::PEND_W-1:0]    rsp_pending_count
);
   import pfsf_pkg::*;

   localparam int unsigned IDX_W = $clog2(FIFO_DEPTH);
   localparam int unsigned CW    = (IDX_W > PEND_W) ? IDX_W : PEND_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FIFO_DEPTH - 1);

   back_state_type state_ff, state_in;
   back_ctrl_type  ctrl;

   logic [SYM_W-1:0]  mem [FIFO_DEPTH];
   logic [SYM_W-1:0]  rd_data_ff;

   logic [IDX_W-1:0]  wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]  count_ff, count_in;
   logic [DATA_W-1:0] countdown_ff, countdown_in;

   logic              mem_we;
   logic              mem_re;
   logic              pop_hit;
   logic [CW-1:0]     count_ext;
   logic [PEND_W-1:0] pend_now;
   logic [PEND_W-1:0] pend_ff, pend_in;

   logic [TONE_W-1:0]      base_ff;
   logic [OFFS_W-1:0]      offs_ff;
   logic [OFFS_PROD_W-1:0] offs_prod;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_acc_ff, rsp_acc_in;
   logic                rsp_tv_ff, rsp_tv_in;
   logic [TONE_W-1:0]   rsp_tone_ff, rsp_tone_in;
   logic [PEND_W-1:0]   rsp_pend_ff, rsp_pend_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE:  state_in = (ctrl.exec && pop_hit) ? B_MUL : B_IDLE;
         B_MUL:   state_in = B_SUM;
         B_SUM:   state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      ctrl = '0;
      case (state_ff)
         B_IDLE: begin
            ctrl.exec  = q_head.valid;
            ctrl.q_pop = q_head.valid;
         end
         B_MUL:   ctrl.do_mul = 1'b1;
         B_SUM:   ctrl.do_sum = 1'b1;
         default: ctrl = '0;
      endcase
   end

   assign q_pop = ctrl.q_pop;

   // FIFO and countdown update
   always_comb begin
      wr_idx_in    = wr_idx_ff;
      rd_idx_in    = rd_idx_ff;
      count_in     = count_ff;
      countdown_in = countdown_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      pop_hit      = 1'b0;
      rsp_acc_in   = 1'b0;
      if (ctrl.exec) begin
         case (q_head.item.cmd)
            CMD_PUSH: begin
               if (count_ff < LAST_IDX) begin
                  mem_we     = 1'b1;
                  wr_idx_in  = (wr_idx_ff == LAST_IDX) ? '0 : wr_idx_ff + 1'b1;
                  count_in   = count_ff + 1'b1;
                  rsp_acc_in = 1'b1;
               end
            end
            CMD_TICK: begin
               if (countdown_ff <= DATA_W'(1)) begin
                  countdown_in = sym_period;
                  if (count_ff != '0) begin
                     mem_re    = 1'b1;
                     pop_hit   = 1'b1;
                     rd_idx_in = (rd_idx_ff == LAST_IDX) ? '0 : rd_idx_ff + 1'b1;
                     count_in  = count_ff - 1'b1;
                  end
               end else begin
                  countdown_in = countdown_ff - 1'b1;
               end
            end
            CMD_CLEAR: begin
               wr_idx_in = '0;
               rd_idx_in = '0;
               count_in  = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   // saturate the held count
   always_comb begin
      count_ext = CW'(count_in);
      pend_now  = (count_ext > CW'(255)) ? PEND_W'(255) : count_ext[PEND_W-1:0];
      pend_in   = (ctrl.exec && pop_hit) ? pend_now : pend_ff;
   end

   assign offs_prod = OFFS_PROD_W'(rd_data_ff) * OFFS_PROD_W'(OFFS_MUL);

   // result register
   always_comb begin
      rsp_valid_in = 1'b0;
      rsp_tv_in    = 1'b0;
      rsp_tone_in  = '0;
      rsp_pend_in  = rsp_pend_ff;
      if (ctrl.exec && !pop_hit) begin
         rsp_valid_in = 1'b1;
         rsp_pend_in  = pend_now;
      end else if (ctrl.do_sum) begin
         rsp_valid_in = 1'b1;
         rsp_tv_in    = 1'b1;
         rsp_tone_in  = base_ff + TONE_W'(offs_ff);
         rsp_pend_in  = pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         count_ff     <= '0;
         countdown_ff <= FIRST_DELAY;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_idx_ff    <= wr_idx_in;
         rd_idx_ff    <= rd_idx_in;
         count_ff     <= count_in;
         countdown_ff <= countdown_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      rsp_acc_ff  <= rsp_acc_in;
      rsp_tv_ff   <= rsp_tv_in;
      rsp_tone_ff <= rsp_tone_in;
      rsp_pend_ff <= rsp_pend_in;
      if (ctrl.do_mul) begin
         base_ff <= TONE_W'(dial_freq_hz) * TONE_W'(CENTI_MUL);
         offs_ff <= offs_prod[OFFS_PROD_W-1:OFFS_SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_idx_ff] <= q_head.item.symbol;
      end
      if (mem_re) begin
         rd_data_ff <= mem[rd_idx_ff];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_push_accepted = rsp_acc_ff;
   assign rsp_tone_valid    = rsp_tv_ff;
   assign rsp_tone_centihz  = rsp_tone_ff;
   assign rsp_pending_count = rsp_pend_ff;

endmodule

[sv/paced_fsk_symbol_fifo_unit.sv]
`timescale 1ns / 1ps

// Paced FSK symbol FIFO.
// Input channel: a command beat (req_opcode, req_symbol) is taken on a clock
// edge with start high and busy low. Opcodes push a symbol, advance time by
// one microsecond tick, or clear the FIFO; the fourth opcode does nothing.
// Result channel: every command yields exactly one result beat, held on the
// rsp_ ports for one cycle and marked by rsp_valid; the receiver cannot stall.
// Commands go into a two-entry queue; the execution side drains it one beat
// at a time. A push, clear or non-popping tick is executed from the queue
// head and its result registered; the execution side stays idle and can take
// the next command without waiting. A tick that pops a symbol reads the symbol
// RAM, then multiplies, then adds, holding the execution side through its
// B_MUL and B_SUM states before it takes another. busy rises while the queue holds two commands.
// Configuration: csr_we writes dial frequency (index 0) or symbol period
// (index 1) into its register at the clock edge; write only while no command is in flight.
// Reset: FIFO empty, tick countdown at 20000, configuration registers at their defaults.
// Symbol RAM contents are not cleared and need no clearing pass.
module paced_fsk_symbol_fifo_unit #(
   parameter int unsigned FIFO_DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [pfsf_pkg::OP_W-1:0]        req_opcode,
   input  logic [pfsf_pkg::SYM_W-1:0]       req_symbol,
   output logic                             rsp_valid,
   output logic                             rsp_push_accepted,
   output logic                             rsp_tone_valid,
   output logic [pfsf_pkg::TONE_W-1:0]      rsp_tone_centihz,
   output logic [pfsf_pkg::PEND_W-1:0]      rsp_pending_count,
   input  logic                             csr_we,
   input  logic [pfsf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pfsf_pkg::DATA_W-1:0]      csr_wdata
);
   import pfsf_pkg::*;

   logic [DATA_W-1:0] dial_ff, dial_in;
   logic [DATA_W-1:0] period_ff, period_in;
   queue_head_type    q_head;
   logic              q_pop;

   always_comb begin
      dial_in   = dial_ff;
      period_in = period_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DIAL:   dial_in   = csr_wdata;
            CSR_PERIOD: period_in = csr_wdata;
            default:    dial_in   = dial_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dial_ff   <= DIAL_RESET;
         period_ff <= PERIOD_RESET;
      end else begin
         dial_ff   <= dial_in;
         period_ff <= period_in;
      end
   end

   pfsf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_opcode (req_opcode),
      .req_symbol (req_symbol),
      .q_head     (q_head),
      .q_pop      (q_pop)
   );

   pfsf_back #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .dial_freq_hz      (dial_ff),
      .sym_period        (period_ff),
      .rsp_valid         (rsp_valid),
      .rsp_push_accepted (rsp_push_accepted),
      .rsp_tone_valid    (rsp_tone_valid),
      .rsp_tone_centihz  (rsp_tone_centihz),
      .rsp_pending_count (rsp_pending_count)
   );

endmodule

[bench/paced_fsk_symbol_fifo_unit_test.sv]
`timescale 1ns / 1ps

module paced_fsk_symbol_fifo_unit_test;
   import pfsf_pkg::*;

   localparam logic [OP_W-1:0] OP_NONE = 2'd3;
   localparam int unsigned STALL_LIMIT = 500;
   localparam int unsigned SETTLE_CYCLES = 10;
   localparam int unsigned WARMUP_TICKS = 20010;

   typedef struct {
      logic [OP_W-1:0]  op;
      logic [SYM_W-1:0] sym;
      int unsigned      gap;
   } symbol_cmd_type;

   typedef struct packed {
      logic              accepted;
      logic              tone_valid;
      logic [TONE_W-1:0] tone;
      logic [PEND_W-1:0] pending;
   } tone_beat_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [OP_W-1:0]      req_opcode = OP_NONE;
   logic [SYM_W-1:0]     req_symbol = '0;
   logic                 rsp_valid;
   logic                 rsp_push_accepted;
   logic                 rsp_tone_valid;
   logic [TONE_W-1:0]    rsp_tone_centihz;
   logic [PEND_W-1:0]    rsp_pending_count;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_DIAL;
   logic [DATA_W-1:0]    csr_wdata = '0;

   symbol_cmd_type cmd_backlog[$];
   tone_beat_type  tone_beats_due[$];
   int unsigned mismatches = 0;
   int unsigned idle_cycles = 0;
   int unsigned gap_left = 0;
   bit          gap_armed = 1'b0;

   logic [SYM_W-1:0] sym_ram [0:255];
   logic [7:0]       wr_ptr = '0;
   logic [7:0]       rd_ptr = '0;
   logic [31:0]      countdown = FIRST_DELAY;
   logic [31:0]      dial_hz = DIAL_RESET;
   logic [31:0]      period_us = PERIOD_RESET;

   paced_fsk_symbol_fifo_unit uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_symbol        (req_symbol),
      .rsp_valid         (rsp_valid),
      .rsp_push_accepted (rsp_push_accepted),
      .rsp_tone_valid    (rsp_tone_valid),
      .rsp_tone_centihz  (rsp_tone_centihz),
      .rsp_pending_count (rsp_pending_count),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   function automatic tone_beat_type step_fifo(input logic [OP_W-1:0] op,
                                               input logic [SYM_W-1:0] sym);
      tone_beat_type b;
      logic [7:0]    held;
      logic [63:0]   tone64;
      b = '0;
      held = wr_ptr - rd_ptr;
      case (op)
         OP_PUSH: begin
            if (held < 8'd255) begin
               sym_ram[wr_ptr] = sym;
               wr_ptr = wr_ptr + 8'd1;
               b.accepted = 1'b1;
            end
         end
         OP_TICK: begin
            if (countdown <= 32'd1) begin
               countdown = period_us;
               if (held != 8'd0) begin
                  tone64 = {32'd0, dial_hz} * 64'd100
                         + ({56'd0, sym_ram[rd_ptr]} * 64'd1200000) / 64'd8192;
                  rd_ptr = rd_ptr + 8'd1;
                  b.tone_valid = 1'b1;
                  b.tone = tone64[TONE_W-1:0];
               end
            end else begin
               countdown = countdown - 32'd1;
            end
         end
         OP_CLEAR: begin
            wr_ptr = '0;
            rd_ptr = '0;
         end
         default: ;
      endcase
      b.pending = wr_ptr - rd_ptr;
      return b;
   endfunction

   function automatic void add_cmd(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                                   input int unsigned gap);
      symbol_cmd_type c;
      c.op = op;
      c.sym = sym;
      c.gap = gap;
      cmd_backlog.push_back(c);
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_DIAL)
         dial_hz = data;
      else
         period_us = data;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained;
      do @(posedge clock);
      while (cmd_backlog.size() != 0 || start || tone_beats_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_traffic(input int unsigned n);
      int unsigned     added;
      int unsigned     len;
      int unsigned     pick;
      logic [OP_W-1:0] op;
      bit              idle;
      added = 0;
      while (added < n) begin
         pick = $urandom_range(0, 99);
         idle = $urandom_range(0, 2) != 0;
         if (pick < 2) begin
            op = OP_PUSH;
            len = 257;
         end else if (pick < 42) begin
            op = OP_PUSH;
            len = $urandom_range(1, 24);
         end else if (pick < 84) begin
            op = OP_TICK;
            len = $urandom_range(1, 24);
         end else if (pick < 92) begin
            op = OP_CLEAR;
            len = 1;
         end else begin
            op = OP_NONE;
            len = 1;
         end
         repeat (len)
            add_cmd(op, SYM_W'($urandom_range(0, 255)), idle ? $urandom_range(0, 18) : 0);
         added += len;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_armed = 1'b0;
      end else begin
         if (start && !busy)
            tone_beats_due.push_back(step_fifo(req_opcode, req_symbol));
         if (!(start && busy)) begin
            if (cmd_backlog.size() != 0) begin
               if (!gap_armed) begin
                  gap_left = cmd_backlog[0].gap;
                  gap_armed = 1'b1;
               end
               if (gap_left == 0) begin
                  start <= 1'b1;
                  req_opcode <= cmd_backlog[0].op;
                  req_symbol <= cmd_backlog[0].sym;
                  void'(cmd_backlog.pop_front());
                  gap_armed = 1'b0;
               end else begin
                  gap_left--;
                  start <= 1'b0;
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : tone_monitor
      tone_beat_type want;
      if (!reset && rsp_valid) begin
         if (tone_beats_due.size() == 0) begin
            $error("result beat with none expected");
            mismatches++;
         end else begin
            want = tone_beats_due.pop_front();
            if (rsp_push_accepted !== want.accepted) begin
               $error("push_accepted: expected %0d, got %0d", want.accepted,
                      rsp_push_accepted);
               mismatches++;
            end
            if (rsp_tone_valid !== want.tone_valid) begin
               $error("tone_valid: expected %0d, got %0d", want.tone_valid, rsp_tone_valid);
               mismatches++;
            end
            if (rsp_tone_centihz !== want.tone) begin
               $error("tone_centihz: expected %0d, got %0d", want.tone, rsp_tone_centihz);
               mismatches++;
            end
            if (rsp_pending_count !== want.pending) begin
               $error("pending_count: expected %0d, got %0d", want.pending,
                      rsp_pending_count);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid) begin
            idle_cycles = 0;
         end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
         end else begin
            idle_cycles++;
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_csr(CSR_PERIOD, 32'd1);
      @(negedge clock);
      add_cmd(OP_PUSH, 8'h00, $urandom_range(0, 18));
      add_cmd(OP_PUSH, 8'hFF, $urandom_range(0, 18));
      add_cmd(OP_PUSH, 8'hA5, 0);
      add_cmd(OP_PUSH, 8'h5A, 0);
      add_cmd(OP_NONE, 8'hFF, $urandom_range(0, 18));
      add_cmd(OP_TICK, 8'h00, 0);
      add_cmd(OP_TICK, 8'hFF, $urandom_range(0, 18));
      add_cmd(OP_CLEAR, 8'h00, 0);
      add_cmd(OP_TICK, 8'h00, 0);
      add_cmd(OP_PUSH, 8'h3C, $urandom_range(0, 18));
      add_cmd(OP_PUSH, 8'hC3, 0);
      add_cmd(OP_PUSH, 8'hFF, 0);
      add_cmd(OP_PUSH, 8'h80, $urandom_range(0, 18));
      // run the countdown out to the first pop, then expire on every tick, popping while symbols remain
      repeat (WARMUP_TICKS) add_cmd(OP_TICK, 8'h00, 0);
      // overfill, partly drain, clear with symbols held, expire on empty
      repeat (257) add_cmd(OP_PUSH, SYM_W'($urandom_range(0, 255)), 0);
      repeat (100) add_cmd(OP_TICK, 8'h00, $urandom_range(0, 1));
      repeat (3) add_cmd(OP_PUSH, SYM_W'($urandom_range(0, 255)), 0);
      add_cmd(OP_CLEAR, 8'hFF, 0);
      repeat (5) add_cmd(OP_TICK, 8'h00, 0);
      wait_drained();

      write_csr(CSR_DIAL, 32'd0);
      write_csr(CSR_PERIOD, 32'd0);
      @(negedge clock);
      queue_traffic(140);
      wait_drained();

      write_csr(CSR_DIAL, 32'hFFFF_FFFF);
      write_csr(CSR_PERIOD, 32'd2);
      @(negedge clock);
      queue_traffic(140);
      wait_drained();

      write_csr(CSR_DIAL, $urandom);
      write_csr(CSR_PERIOD, $urandom_range(1, 5));
      @(negedge clock);
      queue_traffic(140);
      wait_drained();

      write_csr(CSR_DIAL, $urandom);
      write_csr(CSR_PERIOD, $urandom_range(3, 8));
      @(negedge clock);
      queue_traffic(140);
      wait_drained();

      write_csr(CSR_DIAL, DIAL_RESET);
      write_csr(CSR_PERIOD, 32'd1);
      @(negedge clock);
      queue_traffic(140);
      wait_drained();

      write_csr(CSR_DIAL, $urandom);
      write_csr(CSR_PERIOD, 32'hFFFF_FFFF);
      @(negedge clock);
      repeat (4) add_cmd(OP_PUSH, SYM_W'($urandom_range(0, 255)), 0);
      queue_traffic(40);
      wait_drained();

      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
